[hw/rtl/dstf_pkg.sv]
// Shared types and constants for the debounced step timestamp FIFO core.
// No dependencies; every other file refers to it by scoped names.
package dstf_pkg;

   // Fixed widths of the beat fields and the register port.
   localparam int DEBOUNCE_BITS   = 16;
   localparam int COUNT_BITS      = 32;
   localparam int FIELD_TIME_BITS = 48;
   localparam int STORED_BITS     = 8;
   localparam int WIDE_TIME_BITS  = 64;
   localparam int CSR_ADDR_BITS   = 3;
   localparam int CSR_DATA_BITS   = 32;

   // Defaults for the top-level parameters.
   localparam int FIFO_DEPTH_DEFAULT = 128;
   localparam int TIME_BITS_DEFAULT  = 48;

   // Reset value of the debounce length register.
   localparam logic [DEBOUNCE_BITS-1:0] DEBOUNCE_RESET = 16'd80;

   // Register index, taken from paddr[2] (registers are 4 bytes apart).
   localparam logic REG_DEBOUNCE = 1'b0;

   // Input beat kinds.
   localparam logic MODE_TICK = 1'b0;
   localparam logic MODE_POP  = 1'b1;

   typedef enum logic [1:0] {
      POP_NONE  = 2'd0,
      POP_DONE  = 2'd1,
      POP_EMPTY = 2'd2
   } pop_status_type;

   // Requests from the datapath to the timestamp FIFO for one beat.
   typedef struct packed {
      logic push_req;
      logic pop_req;
   } fifo_cmd_type;

   // What the FIFO did with those requests.
   typedef struct packed {
      logic pop_done;
      logic pop_empty;
   } fifo_stat_type;

endpackage

[hw/rtl/debounced_step_timestamp_fifo_core.sv]
// Top level of the debounced step timestamp FIFO core.
// Depends on dstf_pkg, dstf_csr, dstf_debounce and dstf_fifo.
//
// Usage:
// The request channel carries one beat per millisecond tick (req_mode low,
// with the pin sample on req_pin_level) or one pop beat (req_mode high).
// Every request beat yields exactly one response beat, in order, with the
// step flag, the wrapping step total, the time of the latest step, the FIFO
// fill level, and for pop beats the oldest timestamp with its status.
// A request beat is taken into an input register; the debounce logic, the
// counters and the FIFO pointers update in one pass as it moves into the
// response register, from which the response is presented.
// Throughput is one beat per cycle while the receiver does not stall; the
// FIFO memory has one write and one registered read port, which is enough
// because a beat either pushes or pops.
// When the receiver raises rsp_stall the response register holds its beat;
// the input register may still fill, and req_stall rises only when both
// registers are occupied, so no beat is lost or repeated.
// The debounce length sits at byte address 0 of the register port and may
// only be written while no beat is in flight.
// Reset is synchronous: it empties both registers and the FIFO, clears the
// time base and counters, and loads the default debounce length. The FIFO
// memory itself is not cleared; the fill level guards every read.
module debounced_step_timestamp_fifo_core #(
   parameter int FIFO_DEPTH = dstf_pkg::FIFO_DEPTH_DEFAULT,
   parameter int TIME_BITS  = dstf_pkg::TIME_BITS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // Request channel.
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_mode,
   input  logic                                   req_pin_level,
   // Response channel.
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_step_accepted,
   output logic [dstf_pkg::COUNT_BITS-1:0]        rsp_total_count,
   output logic [dstf_pkg::FIELD_TIME_BITS-1:0]   rsp_last_step_time,
   output logic [dstf_pkg::STORED_BITS-1:0]       rsp_stored_count,
   output logic [dstf_pkg::FIELD_TIME_BITS-1:0]   rsp_popped_time,
   output logic [1:0]                             rsp_pop_status,
   // Register port.
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [dstf_pkg::CSR_ADDR_BITS-1:0]     paddr,
   input  logic [dstf_pkg::CSR_DATA_BITS-1:0]     pwdata,
   output logic [dstf_pkg::CSR_DATA_BITS-1:0]     prdata,
   output logic                                   pready
);

   localparam int FILL_BITS = $clog2(FIFO_DEPTH + 1);

   // Input register.
   logic req_valid_ff;
   logic req_mode_ff;
   logic req_pin_ff;

   // Response register.
   logic                              rsp_valid_ff;
   logic                              rsp_accepted_ff;
   logic [dstf_pkg::COUNT_BITS-1:0]   rsp_total_ff;
   logic [TIME_BITS-1:0]              rsp_last_ff;
   logic [dstf_pkg::STORED_BITS-1:0]  rsp_stored_ff;
   dstf_pkg::pop_status_type          rsp_status_ff;
   dstf_pkg::pop_status_type          rsp_status_in;

   logic                              advance;
   logic                              take_req;
   logic                              tick;
   logic [dstf_pkg::DEBOUNCE_BITS-1:0] debounce_ticks;
   logic                              accepted;
   logic [dstf_pkg::COUNT_BITS-1:0]   total_in;
   logic [TIME_BITS-1:0]              latest_in;
   dstf_pkg::fifo_cmd_type            fifo_cmd;
   dstf_pkg::fifo_stat_type           fifo_stat;
   logic [FILL_BITS-1:0]              fill_in;
   logic [TIME_BITS-1:0]              rd_data;
   logic [dstf_pkg::WIDE_TIME_BITS-1:0] last_wide;
   logic [dstf_pkg::WIDE_TIME_BITS-1:0] popped_wide;

   // The beat in the input register moves on whenever the response register
   // is empty or being drained this cycle.
   assign advance  = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = req_valid_ff && !advance;
   assign take_req  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (take_req) begin
         req_valid_ff <= 1'b1;
      end else if (advance) begin
         req_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take_req) begin
         req_mode_ff <= req_mode;
         req_pin_ff  <= req_pin_level;
      end
   end

   assign tick = advance && (req_mode_ff == dstf_pkg::MODE_TICK);

   dstf_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready),
      .debounce_ticks (debounce_ticks)
   );

   dstf_debounce #(
      .TIME_BITS (TIME_BITS)
   ) u_debounce (
      .clock          (clock),
      .reset          (reset),
      .tick           (tick),
      .sample         (req_pin_ff),
      .debounce_ticks (debounce_ticks),
      .accepted       (accepted),
      .total_in       (total_in),
      .latest_in      (latest_in)
   );

   assign fifo_cmd.push_req = accepted;
   assign fifo_cmd.pop_req  = advance && (req_mode_ff == dstf_pkg::MODE_POP);

   dstf_fifo #(
      .FIFO_DEPTH (FIFO_DEPTH),
      .TIME_BITS  (TIME_BITS)
   ) u_fifo (
      .clock   (clock),
      .reset   (reset),
      .cmd     (fifo_cmd),
      .stamp   (latest_in),
      .stat    (fifo_stat),
      .fill_in (fill_in),
      .rd_data (rd_data)
   );

   always_comb begin
      rsp_status_in = dstf_pkg::POP_NONE;
      if (fifo_stat.pop_done) begin
         rsp_status_in = dstf_pkg::POP_DONE;
      end else if (fifo_stat.pop_empty) begin
         rsp_status_in = dstf_pkg::POP_EMPTY;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // The popped timestamp itself is held in the FIFO's read data register,
   // which only changes on a pop and therefore only when this register loads.
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_accepted_ff <= accepted;
         rsp_total_ff    <= total_in;
         rsp_last_ff     <= latest_in;
         rsp_stored_ff   <= dstf_pkg::STORED_BITS'(fill_in);
         rsp_status_ff   <= rsp_status_in;
      end
   end

   assign last_wide   = dstf_pkg::WIDE_TIME_BITS'(rsp_last_ff);
   assign popped_wide = (rsp_status_ff == dstf_pkg::POP_DONE)
                        ? dstf_pkg::WIDE_TIME_BITS'(rd_data) : '0;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_step_accepted  = rsp_accepted_ff;
   assign rsp_total_count    = rsp_total_ff;
   assign rsp_last_step_time = last_wide[dstf_pkg::FIELD_TIME_BITS-1:0];
   assign rsp_stored_count   = rsp_stored_ff;
   assign rsp_popped_time    = popped_wide[dstf_pkg::FIELD_TIME_BITS-1:0];
   assign rsp_pop_status     = rsp_status_ff;

endmodule

[hw/rtl/dstf_csr.sv]
// Register port of the core: holds the debounce length register.
// Depends on dstf_pkg.
module dstf_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [dstf_pkg::CSR_ADDR_BITS-1:0]    paddr,
   input  logic [dstf_pkg::CSR_DATA_BITS-1:0]    pwdata,
   output logic [dstf_pkg::CSR_DATA_BITS-1:0]    prdata,
   output logic                                  pready,
   output logic [dstf_pkg::DEBOUNCE_BITS-1:0]    debounce_ticks
);

   logic [dstf_pkg::DEBOUNCE_BITS-1:0] debounce_ff;
   logic [dstf_pkg::DEBOUNCE_BITS-1:0] debounce_in;
   logic                               wr_hit;

   assign pready = 1'b1;
   assign wr_hit = psel && penable && pwrite && (paddr[2] == dstf_pkg::REG_DEBOUNCE);

   always_comb begin
      debounce_in = debounce_ff;
      if (wr_hit) begin
         debounce_in = pwdata[dstf_pkg::DEBOUNCE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= dstf_pkg::DEBOUNCE_RESET;
      end else begin
         debounce_ff <= debounce_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == dstf_pkg::REG_DEBOUNCE) begin
         prdata = dstf_pkg::CSR_DATA_BITS'(debounce_ff);
      end
   end

   assign debounce_ticks = debounce_ff;

endmodule

[hw/rtl/dstf_debounce.sv]
// Debounce state machine, millisecond time base and step counters.
// Depends on dstf_pkg.
module dstf_debounce #(
   parameter int TIME_BITS = dstf_pkg::TIME_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  tick,
   input  logic                                  sample,
   input  logic [dstf_pkg::DEBOUNCE_BITS-1:0]    debounce_ticks,
   output logic                                  accepted,
   output logic [dstf_pkg::COUNT_BITS-1:0]       total_in,
   output logic [TIME_BITS-1:0]                  latest_in
);

   logic [TIME_BITS-1:0]               time_ff, time_in;
   logic                               prev_ff, prev_in;
   logic                               known_ff, known_in;
   logic                               stable_ff, stable_in;
   logic                               pend_valid_ff, pend_valid_in;
   logic                               pend_value_ff, pend_value_in;
   logic [dstf_pkg::DEBOUNCE_BITS-1:0] count_ff, count_in;
   logic                               running_ff, running_in;
   logic [dstf_pkg::COUNT_BITS-1:0]    total_ff;
   logic [TIME_BITS-1:0]               latest_ff;
   logic                               restarted;

   always_comb begin
      time_in       = time_ff;
      prev_in       = prev_ff;
      known_in      = known_ff;
      stable_in     = stable_ff;
      pend_valid_in = pend_valid_ff;
      pend_value_in = pend_value_ff;
      count_in      = count_ff;
      running_in    = running_ff;
      total_in      = total_ff;
      latest_in     = latest_ff;
      accepted      = 1'b0;
      restarted     = 1'b0;

      if (tick) begin
         time_in = time_ff + TIME_BITS'(1);
         if (!known_ff) begin
            // First sample after reset only sets the stable level.
            known_in  = 1'b1;
            stable_in = sample;
            prev_in   = sample;
         end else begin
            if (sample != prev_ff) begin
               if (sample == stable_ff) begin
                  pend_valid_in = 1'b0;
               end else if (!pend_valid_ff || (pend_value_ff != sample)) begin
                  pend_valid_in = 1'b1;
                  pend_value_in = sample;
                  count_in      = debounce_ticks;
                  running_in    = 1'b1;
                  restarted     = 1'b1;
               end
            end
            prev_in = sample;

            if (running_ff && !restarted) begin
               if (count_ff <= dstf_pkg::DEBOUNCE_BITS'(1)) begin
                  count_in   = '0;
                  running_in = 1'b0;
                  if (pend_valid_in && (sample == pend_value_ff) &&
                      (pend_value_ff != stable_ff)) begin
                     stable_in = pend_value_ff;
                     latest_in = time_in;
                     total_in  = total_ff + dstf_pkg::COUNT_BITS'(1);
                     accepted  = 1'b1;
                  end
               end else begin
                  count_in = count_ff - dstf_pkg::DEBOUNCE_BITS'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff       <= '0;
         prev_ff       <= 1'b0;
         known_ff      <= 1'b0;
         stable_ff     <= 1'b0;
         pend_valid_ff <= 1'b0;
         pend_value_ff <= 1'b0;
         count_ff      <= '0;
         running_ff    <= 1'b0;
         total_ff      <= '0;
         latest_ff     <= '0;
      end else begin
         time_ff       <= time_in;
         prev_ff       <= prev_in;
         known_ff      <= known_in;
         stable_ff     <= stable_in;
         pend_valid_ff <= pend_valid_in;
         pend_value_ff <= pend_value_in;
         count_ff      <= count_in;
         running_ff    <= running_in;
         total_ff      <= total_in;
         latest_ff     <= latest_in;
      end
   end

endmodule

[hw/rtl/dstf_fifo.sv]
// Timestamp FIFO: one memory with write and read pointers and a fill level.
// Depends on dstf_pkg.
module dstf_fifo #(
   parameter int FIFO_DEPTH = dstf_pkg::FIFO_DEPTH_DEFAULT,
   parameter int TIME_BITS  = dstf_pkg::TIME_BITS_DEFAULT,
   localparam int PTR_BITS  = $clog2(FIFO_DEPTH),
   localparam int FILL_BITS = $clog2(FIFO_DEPTH + 1)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  dstf_pkg::fifo_cmd_type     cmd,
   input  logic [TIME_BITS-1:0]       stamp,
   output dstf_pkg::fifo_stat_type    stat,
   output logic [FILL_BITS-1:0]       fill_in,
   output logic [TIME_BITS-1:0]       rd_data
);

   logic [TIME_BITS-1:0] mem [FIFO_DEPTH];
   logic [PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FILL_BITS-1:0] fill_ff;
   logic [TIME_BITS-1:0] rd_data_ff;
   logic                 do_push;
   logic                 do_pop;

   // A step that finds the FIFO full is still counted; its stamp is dropped.
   assign do_push = cmd.push_req && (fill_ff != FILL_BITS'(FIFO_DEPTH));
   assign do_pop  = cmd.pop_req && (fill_ff != '0);

   assign stat.pop_done  = do_pop;
   assign stat.pop_empty = cmd.pop_req && (fill_ff == '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(FIFO_DEPTH - 1)) ? '0
                                                              : wr_ptr_ff + PTR_BITS'(1);
         fill_in   = fill_ff + FILL_BITS'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(FIFO_DEPTH - 1)) ? '0
                                                              : rd_ptr_ff + PTR_BITS'(1);
         fill_in   = fill_ff - FILL_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= stamp;
      end
   end

   always_ff @(posedge clock) begin
      if (do_pop) begin
         rd_data_ff <= mem[rd_ptr_ff];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/dstf_checker.sv]
// Port-level checks for the debounced step timestamp FIFO core, with its bind.
// Depends on dstf_pkg and debounced_step_timestamp_fifo_core.
module dstf_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   rsp_valid,
   input logic                                   rsp_stall,
   input logic                                   rsp_step_accepted,
   input logic [dstf_pkg::COUNT_BITS-1:0]        rsp_total_count,
   input logic [dstf_pkg::STORED_BITS-1:0]       rsp_stored_count,
   input logic [dstf_pkg::FIELD_TIME_BITS-1:0]   rsp_popped_time,
   input logic [1:0]                             rsp_pop_status
);

   // A stalled response beat stays presented.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response beat dropped while stalled");

   // A stalled response beat keeps its counters.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_total_count) && $stable(rsp_stored_count))
      else $error("response payload changed while stalled");

   // A step is only ever reported on a tick beat.
   a_step_on_tick: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_step_accepted |-> rsp_pop_status == dstf_pkg::POP_NONE)
      else $error("step reported on a pop beat");

   // An empty pop leaves the FIFO empty and returns no timestamp.
   a_empty_pop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pop_status == dstf_pkg::POP_EMPTY
      |-> rsp_stored_count == '0 && rsp_popped_time == '0)
      else $error("empty pop with stored data or a timestamp");

   // Beats that did not pop carry no timestamp.
   a_no_pop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pop_status == dstf_pkg::POP_NONE |-> rsp_popped_time == '0)
      else $error("timestamp on a beat without a pop");

endmodule

bind debounced_step_timestamp_fifo_core dstf_checker u_dstf_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_step_accepted (rsp_step_accepted),
   .rsp_total_count   (rsp_total_count),
   .rsp_stored_count  (rsp_stored_count),
   .rsp_popped_time   (rsp_popped_time),
   .rsp_pop_status    (rsp_pop_status)
);
